// ----- rtl/plt_pkg.sv -----
`default_nettype none

package plt_pkg;

    // Breakpoint table depth.
    localparam int MAX_POINTS = 16;

    // Field widths.
    localparam int PIX_W = 8;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int N_W   = $clog2(MAX_POINTS + 1);

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_POINT_COUNT = 1'b0;
    localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 5'd2;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Interpolation datapath widths.
    localparam int DY_W   = PIX_W + 1;
    localparam int PROD_W = 2 * DY_W;
    localparam int QUOT_W = PIX_W + 1;
    localparam int DIV_W  = PIX_W + 1;
    localparam int DSH_W  = DIV_W + QUOT_W - 1;
    localparam int REM_W  = DSH_W + 1;
    localparam int SUM_W  = REM_W + 2;
    localparam int Y_W    = QUOT_W + 2;
    localparam int OFFSET = 1 << (QUOT_W - 1);

    typedef struct packed {
        logic             ident;
        logic             at_end;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] x0;
        logic [PIX_W-1:0] x1;
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] y1;
    } seg_t;

    typedef struct packed {
        logic              byp;
        logic [REM_W-1:0]  rem;
        logic [DSH_W-1:0]  dsh;
        logic [QUOT_W-1:0] quot;
        logic [PIX_W-1:0]  y0;
    } div_t;

endpackage

`default_nettype wire

// ----- rtl/plt_req_if.sv -----
`default_nettype none

interface plt_req_if;
    import plt_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] point_index;
    logic [PIX_W-1:0] point_x;
    logic [PIX_W-1:0] point_y;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, func, point_index, point_x, point_y, pixel, input ready);
    modport sink   (input valid, func, point_index, point_x, point_y, pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/plt_rsp_if.sv -----
`default_nettype none

interface plt_rsp_if;
    import plt_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mapped;

    modport source (output valid, mapped, input ready);
    modport sink   (input valid, mapped, output ready);
endinterface

`default_nettype wire

// ----- rtl/plt_cfg_regs.sv -----
`default_nettype none

module plt_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [plt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [plt_pkg::DATA_W-1:0] pwdata,
    output logic      [plt_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output logic      [plt_pkg::CNT_W-1:0]  point_count
);
    import plt_pkg::*;

    logic [CNT_W-1:0] point_count_reg;
    logic             hit;

    assign hit = (paddr[ADDR_W-1:2] == REG_POINT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            point_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata      = hit ? DATA_W'(point_count_reg) : '0;
    assign pready      = 1'b1;
    assign point_count = point_count_reg;

endmodule

`default_nettype wire

// ----- rtl/plt_seg_select.sv -----
`default_nettype none

module plt_seg_select (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      take,
    input  wire logic                      func,
    input  wire logic [plt_pkg::IDX_W-1:0] point_index,
    input  wire logic [plt_pkg::PIX_W-1:0] point_x,
    input  wire logic [plt_pkg::PIX_W-1:0] point_y,
    input  wire logic [plt_pkg::PIX_W-1:0] pixel,
    input  wire logic [plt_pkg::CNT_W-1:0] point_count,
    output logic                           seg_valid,
    output plt_pkg::seg_t                  seg
);
    import plt_pkg::*;

    logic [PIX_W-1:0]      bx_reg [MAX_POINTS];
    logic [PIX_W-1:0]      by_reg [MAX_POINTS];
    logic [N_W-1:0]        n;
    logic [MAX_POINTS-1:0] cont;
    logic [MAX_POINTS-1:0] sel;
    seg_t                  seg_next;
    seg_t                  seg_reg;
    logic                  seg_valid_reg;

    // Table writes land at the edge that accepts the write beat, so any map
    // beat accepted later reads the updated entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                bx_reg[k] <= (k == 1) ? PIX_MAX : '0;
                by_reg[k] <= (k == 1) ? PIX_MAX : '0;
            end
        end
        else if (take && adv && (func == FUNC_WRITE))
        begin
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                if (int'(point_index) == k)
                begin
                    bx_reg[k] <= point_x;
                    by_reg[k] <= point_y;
                end
            end
        end
    end

    assign n = (int'(point_count) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(point_count);

    // The search moves past segment k while its right end lies below the pixel;
    // the selected segment is the first one where it stops.
    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cmp
        localparam logic [MAX_POINTS-1:0] LOW = (MAX_POINTS'(1) << k) - MAX_POINTS'(1);
        if (k < MAX_POINTS - 1)
        begin : g_cont
            assign cont[k] = ((k + 1) < int'(n)) && (bx_reg[k+1] < pixel);
        end
        else
        begin : g_last
            assign cont[k] = 1'b0;
        end
        assign sel[k] = !cont[k] && ((cont | ~LOW) == '1);
    end

    always_comb
    begin
        seg_next        = '0;
        seg_next.pix    = pixel;
        seg_next.ident  = (n < N_W'(2));
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            if (sel[k])
            begin
                seg_next.x0 = seg_next.x0 | bx_reg[k];
                seg_next.y0 = seg_next.y0 | by_reg[k];
            end
            if (sel[k] && ((k + 1) == int'(n)))
            begin
                seg_next.at_end = 1'b1;
            end
        end
        for (int k = 0; k < MAX_POINTS - 1; k++)
        begin
            if (sel[k])
            begin
                seg_next.x1 = seg_next.x1 | bx_reg[k+1];
                seg_next.y1 = seg_next.y1 | by_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            seg_valid_reg <= take && (func == FUNC_MAP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sel))
        else $error("segment select is not one-hot");

    a_seg_right: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid_reg && !seg_reg.ident && !seg_reg.at_end |-> seg_reg.x1 >= seg_reg.pix)
        else $error("selected segment ends below the pixel");

endmodule

`default_nettype wire

// ----- rtl/plt_div_step.sv -----
`default_nettype none

module plt_div_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire plt_pkg::div_t d_in,
    output logic               out_valid,
    output plt_pkg::div_t      d_out
);
    import plt_pkg::*;

    logic ge;
    div_t d_next;
    div_t d_reg;
    logic valid_reg;

    // One restoring step: try the divisor at the current weight.
    assign ge = (d_in.rem >= REM_W'(d_in.dsh));

    always_comb
    begin
        d_next      = d_in;
        d_next.rem  = ge ? (d_in.rem - REM_W'(d_in.dsh)) : d_in.rem;
        d_next.quot = {d_in.quot[QUOT_W-2:0], ge};
        d_next.dsh  = d_in.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign d_out     = d_reg;

endmodule

`default_nettype wire

// ----- rtl/plt_interp.sv -----
`default_nettype none

module plt_interp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 seg_valid,
    input  wire plt_pkg::seg_t        seg,
    output logic                      out_valid,
    output logic [plt_pkg::PIX_W-1:0] mapped
);
    import plt_pkg::*;

    logic signed [DY_W-1:0]   dx;
    logic signed [DY_W-1:0]   dy;
    logic                     hold;
    logic                     b_valid_reg;
    logic                     b_byp_reg;
    logic [PIX_W-1:0]         b_y0_reg;
    logic signed [PROD_W-1:0] b_num_reg;
    logic [PIX_W-1:0]         b_den_reg;
    logic signed [SUM_W-1:0]  sum_c;
    div_t                     c_next;
    div_t                     dv [QUOT_W+1];
    logic                     dv_valid [QUOT_W+1];
    div_t                     c_reg;
    logic                     c_valid_reg;
    logic signed [Y_W-1:0]    y_full;
    logic [PIX_W-1:0]         mapped_next;
    logic [PIX_W-1:0]         mapped_reg;
    logic                     out_valid_reg;

    // Ends of the table, a zero-width segment and a short table all pass y0
    // (or the pixel itself) straight through.
    assign hold = seg.at_end || (seg.x0 > seg.pix) || (seg.x1 <= seg.x0);
    assign dx   = $signed({1'b0, seg.pix - seg.x0});
    assign dy   = $signed({1'b0, seg.y1}) - $signed({1'b0, seg.y0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= seg_valid;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= dv_valid[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_byp_reg  <= seg.ident || hold;
            b_y0_reg   <= seg.ident ? seg.pix : seg.y0;
            b_num_reg  <= dx * dy;
            b_den_reg  <= seg.x1 - seg.x0;
            c_reg      <= c_next;
            mapped_reg <= mapped_next;
        end
    end

    // The quotient is biased by OFFSET so that the dividend stays positive:
    // dividend = 2*num + den + 2*den*OFFSET, divisor = 2*den.
    assign sum_c = (SUM_W'(b_num_reg) <<< 1)
                 + SUM_W'({b_den_reg, {QUOT_W{1'b0}}})
                 + SUM_W'(b_den_reg);

    always_comb
    begin
        c_next      = '0;
        c_next.byp  = b_byp_reg;
        c_next.y0   = b_y0_reg;
        c_next.rem  = sum_c[REM_W-1:0];
        c_next.dsh  = {b_den_reg, 1'b0, {(QUOT_W-1){1'b0}}};
    end

    assign dv[0]       = c_reg;
    assign dv_valid[0] = c_valid_reg;

    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_div
        plt_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_valid[g]),
            .d_in      (dv[g]),
            .out_valid (dv_valid[g+1]),
            .d_out     (dv[g+1])
        );
    end

    assign y_full = $signed(Y_W'(dv[QUOT_W].y0)) + $signed(Y_W'(dv[QUOT_W].quot))
                  - $signed(Y_W'(OFFSET));

    always_comb
    begin
        if (dv[QUOT_W].byp)
        begin
            mapped_next = dv[QUOT_W].y0;
        end
        else if (y_full < 0)
        begin
            mapped_next = '0;
        end
        else if (y_full > $signed(Y_W'(PIX_MAX)))
        begin
            mapped_next = PIX_MAX;
        end
        else
        begin
            mapped_next = y_full[PIX_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign mapped    = mapped_reg;

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !c_reg.byp |-> c_reg.rem < {c_reg.dsh, 1'b0})
        else $error("interpolation quotient overflows the divider");

endmodule

`default_nettype wire

// ----- rtl/piecewise_linear_tone_curve_core.sv -----
`default_nettype none

// Piecewise-linear tone curve for 8-bit pixels. Beats on req either write a
// breakpoint (func write: point_index, point_x, point_y) or map a pixel (func
// map), and every map beat yields exactly one beat on rsp carrying the mapped
// level; write beats yield nothing. Breakpoints must be loaded in ascending x
// order and take effect for every map beat accepted after the write beat.
// The number of breakpoints in use is the point_count register at APB address
// 0 (reset 2, table reset holding the identity line); below two points the
// curve is the identity, and point_count should only be changed while the
// block is idle. The datapath is a pipeline of thirteen register stages: the
// segment search over the whole table in one stage, the slope multiply in
// the next, the biased dividend in the third, then a nine-step restoring
// divider at one quotient bit per stage and a final unbiasing and clamping
// stage. One beat is accepted every clock unless the pipeline is held; the
// whole pipeline holds while a finished result waits on rsp, so req.ready
// follows the output register being empty or being drained.
module piecewise_linear_tone_curve_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [plt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [plt_pkg::DATA_W-1:0] pwdata,
    output logic      [plt_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    plt_req_if.sink                         req,
    plt_rsp_if.source                       rsp
);
    import plt_pkg::*;

    logic             adv;
    logic [CNT_W-1:0] point_count;
    logic             seg_valid;
    seg_t             seg;
    logic             out_valid;
    logic [PIX_W-1:0] mapped;

    // Every stage moves on together whenever the output register is free.
    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;

    plt_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .point_count (point_count)
    );

    // Breakpoint table and segment search; the selected endpoints are
    // captured with the beat so later table writes cannot disturb it.
    plt_seg_select u_sel (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .take        (req.valid),
        .func        (req.func),
        .point_index (req.point_index),
        .point_x     (req.point_x),
        .point_y     (req.point_y),
        .pixel       (req.pixel),
        .point_count (point_count),
        .seg_valid   (seg_valid),
        .seg         (seg)
    );

    // Multiply, biased divide with round-half-up, clamp and output register.
    plt_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .seg_valid (seg_valid),
        .seg       (seg),
        .out_valid (out_valid),
        .mapped    (mapped)
    );

    assign rsp.valid  = out_valid;
    assign rsp.mapped = mapped;

endmodule

`default_nettype wire
